>>> hdl/ffha_pkg.sv
package ffha_pkg;

  // Default sizes of the heap and of the block table.
  localparam int unsigned HEAP_BYTES_DEF = 1048576;
  localparam int unsigned MAX_BLOCKS_DEF = 1024;

  // Width of the size and offset fields on the ports.
  localparam int unsigned FIELD_W = 20;

  // Every block carries a header of this many bytes in front of its payload.
  localparam int unsigned HDR_BYTES = 16;

  // Request operations.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_UNKNOWN   = 2'd3;

  // Verdict of the entry compare unit for the entry under test.
  typedef struct packed {
    logic fit;       // free block large enough for the allocate
    logic hit;       // payload offset equals the offset to free
    logic overflow;  // appending at the heap end would reach the heap size
  } match_t;

endpackage

>>> hdl/ffha_mem.sv
module ffha_mem #(
  parameter int unsigned Depth = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned Width = 41,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hdl/ffha_unit.sv
module ffha_unit #(
  parameter int unsigned HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF,
  parameter int unsigned HeapW      = $clog2(HEAP_BYTES)
) (
  input  logic [ffha_pkg::FIELD_W-1:0] req_size_i,
  input  logic [ffha_pkg::FIELD_W-1:0] req_off_i,
  input  logic [HeapW-1:0]             ent_start_i,
  input  logic [ffha_pkg::FIELD_W-1:0] ent_bytes_i,
  input  logic                         ent_free_i,
  input  logic [HeapW-1:0]             heap_end_i,
  output ffha_pkg::match_t             match_o,
  output logic [ffha_pkg::FIELD_W-1:0] ent_off_o,
  output logic [ffha_pkg::FIELD_W-1:0] app_off_o,
  output logic [HeapW-1:0]             new_end_o
);

  localparam int unsigned OffW =
      ((HeapW > ffha_pkg::FIELD_W) ? HeapW : ffha_pkg::FIELD_W) + 1;
  localparam int unsigned SumW = OffW + 1;

  logic [OffW-1:0] ent_off_full;
  logic [OffW-1:0] app_off_full;
  logic [SumW-1:0] new_end_full;

  // Payload offsets are reported modulo 2^20, also for a wider heap.
  assign ent_off_full = OffW'(ent_start_i) + OffW'(ffha_pkg::HDR_BYTES);
  assign app_off_full = OffW'(heap_end_i) + OffW'(ffha_pkg::HDR_BYTES);
  assign ent_off_o    = ent_off_full[ffha_pkg::FIELD_W-1:0];
  assign app_off_o    = app_off_full[ffha_pkg::FIELD_W-1:0];

  assign new_end_full = SumW'(heap_end_i) + SumW'(ffha_pkg::HDR_BYTES) + SumW'(req_size_i);
  assign new_end_o    = new_end_full[HeapW-1:0];

  assign match_o.fit      = ent_free_i && (ent_bytes_i >= req_size_i);
  assign match_o.hit      = (ent_off_o == req_off_i);
  assign match_o.overflow = (new_end_full >= SumW'(HEAP_BYTES));

endmodule

>>> hdl/first_fit_heap_allocator.sv
// First-fit heap allocator. Each transfer on the input channel is an allocate
// or a free; each gives exactly one transfer on the output channel. The block
// table is one memory with a single read port, scanned in address order at
// one entry per cycle through one shared compare unit; a free of the null
// offset skips the scan. The block is not ready while it works on an item;
// a finished result waits in the output register while the next item is
// accepted. The table needs no clearing after reset: only entries below
// the block count are ever read.
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF,
  parameter int unsigned MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         operation_i,
  input  logic [ffha_pkg::FIELD_W-1:0] request_size_i,
  input  logic [ffha_pkg::FIELD_W-1:0] payload_offset_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ffha_pkg::FIELD_W-1:0] result_offset_o,
  output logic [1:0]                   status_o
);

  localparam int unsigned HW    = $clog2(HEAP_BYTES);
  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned FW    = ffha_pkg::FIELD_W;
  localparam int unsigned ENT_W = HW + FW + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0]       state_q, state_d;
  logic             op_q, op_d;
  logic [FW-1:0]    size_q, size_d;
  logic [FW-1:0]    off_q, off_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             rvld_q, rvld_d;
  logic [IDX_W-1:0] rtag_q, rtag_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [HW-1:0]    heap_end_q, heap_end_d;
  logic [FW-1:0]    res_off_q, res_off_d;
  logic [1:0]       res_st_q, res_st_d;
  logic             out_valid_q, out_valid_d;
  logic [FW-1:0]    out_off_q, out_off_d;
  logic [1:0]       out_st_q, out_st_d;

  logic             issue_en;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [ENT_W-1:0] mem_wd;
  logic [ENT_W-1:0] rd_data;

  logic [HW-1:0]    ent_start;
  logic [FW-1:0]    ent_bytes;
  logic             ent_free;

  ffha_pkg::match_t match;
  logic [FW-1:0]    ent_off;
  logic [FW-1:0]    app_off;
  logic [HW-1:0]    new_end;

  assign ent_start = rd_data[ENT_W-1 -: HW];
  assign ent_bytes = rd_data[FW:1];
  assign ent_free  = rd_data[0];

  assign issue_en = (state_q == S_SCAN) && (idx_q < count_q);

  ffha_mem #(
    .Depth (MAX_BLOCKS),
    .Width (ENT_W),
    .AddrW (IDX_W)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_wa),
    .wr_data_i (mem_wd),
    .rd_en_i   (issue_en),
    .rd_addr_i (idx_q[IDX_W-1:0]),
    .rd_data_o (rd_data)
  );

  ffha_unit #(
    .HEAP_BYTES (HEAP_BYTES),
    .HeapW      (HW)
  ) u_unit (
    .req_size_i  (size_q),
    .req_off_i   (off_q),
    .ent_start_i (ent_start),
    .ent_bytes_i (ent_bytes),
    .ent_free_i  (ent_free),
    .heap_end_i  (heap_end_q),
    .match_o     (match),
    .ent_off_o   (ent_off),
    .app_off_o   (app_off),
    .new_end_o   (new_end)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    size_d      = size_q;
    off_d       = off_q;
    idx_d       = idx_q;
    rvld_d      = rvld_q;
    rtag_d      = rtag_q;
    count_d     = count_q;
    heap_end_d  = heap_end_q;
    res_off_d   = res_off_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_off_d   = out_off_q;
    out_st_d    = out_st_q;
    mem_we      = 1'b0;
    mem_wa      = rtag_q;
    mem_wd      = rd_data;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d   = operation_i;
          size_d = request_size_i;
          off_d  = payload_offset_i;
          idx_d  = '0;
          rvld_d = 1'b0;
          if ((operation_i == ffha_pkg::OP_FREE) && (payload_offset_i == '0)) begin
            res_off_d = '0;
            res_st_d  = ffha_pkg::ST_OK;
            state_d   = S_RESP;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // One read goes out per cycle; its data is judged in the next cycle.
        if (issue_en) begin
          idx_d = idx_q + CNT_W'(1);
        end
        rvld_d = issue_en;
        rtag_d = idx_q[IDX_W-1:0];

        if (rvld_q && (op_q == ffha_pkg::OP_ALLOC) && match.fit) begin
          mem_we    = 1'b1;
          mem_wd    = {ent_start, ent_bytes, 1'b0};
          res_off_d = ent_off;
          res_st_d  = ffha_pkg::ST_OK;
          state_d   = S_RESP;
        end else if (rvld_q && (op_q == ffha_pkg::OP_FREE) && match.hit) begin
          if ((CNT_W'(rtag_q) + CNT_W'(1)) == count_q) begin
            // The last block leaves the table and the heap shrinks to its start.
            count_d    = count_q - CNT_W'(1);
            heap_end_d = ent_start;
          end else begin
            mem_we = 1'b1;
            mem_wd = {ent_start, ent_bytes, 1'b1};
          end
          res_off_d = '0;
          res_st_d  = ffha_pkg::ST_OK;
          state_d   = S_RESP;
        end else if (!issue_en) begin
          // The scan has run past the last entry without a match.
          res_off_d = '0;
          state_d   = S_RESP;
          if (op_q == ffha_pkg::OP_FREE) begin
            res_st_d = ffha_pkg::ST_UNKNOWN;
          end else if (match.overflow) begin
            res_st_d = ffha_pkg::ST_EXHAUSTED;
          end else if (count_q == CNT_W'(MAX_BLOCKS)) begin
            res_st_d = ffha_pkg::ST_FULL;
          end else begin
            mem_we     = 1'b1;
            mem_wa     = count_q[IDX_W-1:0];
            mem_wd     = {heap_end_q, size_q, 1'b0};
            count_d    = count_q + CNT_W'(1);
            heap_end_d = new_end;
            res_off_d  = app_off;
            res_st_d   = ffha_pkg::ST_OK;
          end
        end
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_off_d   = res_off_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rvld_q      <= 1'b0;
      count_q     <= '0;
      heap_end_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rvld_q      <= rvld_d;
      count_q     <= count_d;
      heap_end_q  <= heap_end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    size_q    <= size_d;
    off_q     <= off_d;
    idx_q     <= idx_d;
    rtag_q    <= rtag_d;
    res_off_q <= res_off_d;
    res_st_q  <= res_st_d;
    out_off_q <= out_off_d;
    out_st_q  <= out_st_d;
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign result_offset_o = out_off_q;
  assign status_o        = out_st_q;

endmodule

>>> hdl/ffha_chk.sv
module ffha_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         operation_i,
  input logic [ffha_pkg::FIELD_W-1:0] request_size_i,
  input logic [ffha_pkg::FIELD_W-1:0] payload_offset_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [ffha_pkg::FIELD_W-1:0] result_offset_o,
  input logic [1:0]                   status_o
);

  // The block works on one item at a time, so it drops ready after a transfer.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a previous item is in progress");

  // Only a successful allocate carries a nonzero offset.
  a_fail_zero_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && (status_o != ffha_pkg::ST_OK) |-> (result_offset_o == '0))
    else $error("failed request reports a nonzero offset");

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !out_ready_i |=>
        out_valid_o && $stable(result_offset_o) && $stable(status_o))
    else $error("stalled result changed before its transfer");

  // A request that needs a table scan keeps the input side busy through the
  // scan state and the hand-over of its result.
  a_scan_takes_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && in_ready_o &&
        !((operation_i == ffha_pkg::OP_FREE) && (payload_offset_i == '0))
        |=> !in_ready_o [*2])
    else $error("scan skipped after an accepted request");

  // A waiting request holds its payload until its transfer.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && !in_ready_o |=>
        in_valid_i && $stable(operation_i) && $stable(request_size_i) &&
        $stable(payload_offset_i))
    else $error("waiting request changed before its transfer");

endmodule

bind first_fit_heap_allocator ffha_chk u_ffha_chk (.*);

>>> sim/tb_first_fit_heap_allocator.sv
module tb_first_fit_heap_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HEAP_SIZE   = ffha_pkg::HEAP_BYTES_DEF;
  localparam int unsigned TABLE_DEPTH = ffha_pkg::MAX_BLOCKS_DEF;
  localparam int unsigned FW          = ffha_pkg::FIELD_W;
  localparam int unsigned N_RANDOM    = 520;
  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned N_DIRECTED  = 22;
  localparam int unsigned MAX_LIVE    = 40;

  typedef struct packed {
    logic [FW-1:0] offset;
    logic [1:0]    status;
  } reply_t;

  typedef struct packed {
    logic          op;
    logic [FW-1:0] size;
    logic [FW-1:0] off;
    logic          typed;
    logic [FW-1:0] exp_off;
    logic [1:0]    exp_st;
  } dir_row_t;

  logic          clk_i            = 1'b0;
  logic          rst_ni           = 1'b0;
  logic          in_valid_i       = 1'b0;
  logic          in_ready_o;
  logic          operation_i      = ffha_pkg::OP_ALLOC;
  logic [FW-1:0] request_size_i   = '0;
  logic [FW-1:0] payload_offset_i = '0;
  logic          out_valid_o;
  logic          out_ready_i      = 1'b1;
  logic [FW-1:0] result_offset_o;
  logic [1:0]    status_o;

  // Shadow copy of the block table and heap end.
  logic [FW-1:0] shadow_start [TABLE_DEPTH];
  logic [FW-1:0] shadow_bytes [TABLE_DEPTH];
  logic          shadow_free  [TABLE_DEPTH];
  int unsigned   shadow_count = 0;
  logic [FW-1:0] shadow_end   = '0;
  int unsigned   peak_count   = 0;

  reply_t        pending_replies [$];
  int unsigned   requests_sent = 0;
  int unsigned   replies_seen  = 0;
  int unsigned   mismatches    = 0;
  int unsigned   status_seen [4] = '{0, 0, 0, 0};
  bit            burst_mode    = 1'b0;

  // Null free, empty table, exhaustion at and around the heap size, reuse of a
  // free block, double free, unknown offsets and removal of the last block.
  dir_row_t directed_rows [N_DIRECTED] = '{
    '{ffha_pkg::OP_FREE,  20'hFFFFF,   20'd0,     1'b1, 20'd0,   ffha_pkg::ST_OK},
    '{ffha_pkg::OP_FREE,  20'd0,       20'd16,    1'b1, 20'd0,   ffha_pkg::ST_UNKNOWN},
    '{ffha_pkg::OP_ALLOC, 20'hFFFFF,   20'hFFFFF, 1'b1, 20'd0,   ffha_pkg::ST_EXHAUSTED},
    '{ffha_pkg::OP_ALLOC, 20'd1048560, 20'd0,     1'b1, 20'd0,   ffha_pkg::ST_EXHAUSTED},
    '{ffha_pkg::OP_ALLOC, 20'd1048559, 20'd0,     1'b1, 20'd16,  ffha_pkg::ST_OK},
    '{ffha_pkg::OP_ALLOC, 20'd0,       20'd0,     1'b1, 20'd0,   ffha_pkg::ST_EXHAUSTED},
    '{ffha_pkg::OP_FREE,  20'd0,       20'd16,    1'b1, 20'd0,   ffha_pkg::ST_OK},
    '{ffha_pkg::OP_ALLOC, 20'd100,     20'd0,     1'b1, 20'd16,  ffha_pkg::ST_OK},
    '{ffha_pkg::OP_ALLOC, 20'd0,       20'd0,     1'b1, 20'd132, ffha_pkg::ST_OK},
    '{ffha_pkg::OP_ALLOC, 20'd50,      20'd0,     1'b0, 20'd0,   ffha_pkg::ST_OK},
    '{ffha_pkg::OP_FREE,  20'd0,       20'd16,    1'b1, 20'd0,   ffha_pkg::ST_OK},
    '{ffha_pkg::OP_FREE,  20'd0,       20'd16,    1'b1, 20'd0,   ffha_pkg::ST_OK},
    '{ffha_pkg::OP_ALLOC, 20'd101,     20'd0,     1'b0, 20'd0,   ffha_pkg::ST_OK},
    '{ffha_pkg::OP_ALLOC, 20'd100,     20'd0,     1'b0, 20'd0,   ffha_pkg::ST_OK},
    '{ffha_pkg::OP_FREE,  20'd0,       20'd17,    1'b1, 20'd0,   ffha_pkg::ST_UNKNOWN},
    '{ffha_pkg::OP_FREE,  20'hFFFFF,   20'hFFFFF, 1'b1, 20'd0,   ffha_pkg::ST_UNKNOWN},
    '{ffha_pkg::OP_FREE,  20'd0,       20'd214,   1'b0, 20'd0,   ffha_pkg::ST_OK},
    '{ffha_pkg::OP_FREE,  20'd0,       20'd148,   1'b0, 20'd0,   ffha_pkg::ST_OK},
    '{ffha_pkg::OP_FREE,  20'd0,       20'd148,   1'b0, 20'd0,   ffha_pkg::ST_OK},
    '{ffha_pkg::OP_ALLOC, 20'd0,       20'hFFFFF, 1'b0, 20'd0,   ffha_pkg::ST_OK},
    '{ffha_pkg::OP_FREE,  20'hAAAAA,   20'd132,   1'b0, 20'd0,   ffha_pkg::ST_OK},
    '{ffha_pkg::OP_FREE,  20'd0,       20'd16,    1'b0, 20'd0,   ffha_pkg::ST_OK}
  };

  wire in_fire  = in_valid_i && in_ready_o;
  wire out_fire = out_valid_o && out_ready_i;

  first_fit_heap_allocator #(
    .HEAP_BYTES(HEAP_SIZE),
    .MAX_BLOCKS(TABLE_DEPTH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .request_size_i  (request_size_i),
    .payload_offset_i(payload_offset_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_offset_o (result_offset_o),
    .status_o        (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one request to the shadow table and returns the reply it earns.
  function automatic reply_t heap_update(input logic op, input logic [FW-1:0] size,
                                         input logic [FW-1:0] off);
    reply_t          r;
    longint unsigned new_end;
    int unsigned     i;
    r.offset = '0;
    r.status = ffha_pkg::ST_OK;
    if (op == ffha_pkg::OP_ALLOC) begin
      for (i = 0; i < shadow_count; i++) begin
        if (shadow_free[i] && shadow_bytes[i] >= size) begin
          shadow_free[i] = 1'b0;
          r.offset = shadow_start[i] + FW'(ffha_pkg::HDR_BYTES);
          return r;
        end
      end
      new_end = 64'(shadow_end) + 64'(ffha_pkg::HDR_BYTES) + 64'(size);
      if (new_end >= 64'(HEAP_SIZE)) begin
        r.status = ffha_pkg::ST_EXHAUSTED;
      end else if (shadow_count >= TABLE_DEPTH) begin
        r.status = ffha_pkg::ST_FULL;
      end else begin
        shadow_start[shadow_count] = shadow_end;
        shadow_bytes[shadow_count] = size;
        shadow_free[shadow_count]  = 1'b0;
        r.offset = shadow_end + FW'(ffha_pkg::HDR_BYTES);
        shadow_count++;
        shadow_end = FW'(new_end);
        if (shadow_count > peak_count) peak_count = shadow_count;
      end
      return r;
    end
    if (off == '0) return r;
    for (i = 0; i < shadow_count; i++) begin
      if (shadow_start[i] + FW'(ffha_pkg::HDR_BYTES) == off) begin
        if (i + 1 == shadow_count) begin
          shadow_end = shadow_start[i];
          shadow_count--;
        end else begin
          shadow_free[i] = 1'b1;
        end
        return r;
      end
    end
    r.status = ffha_pkg::ST_UNKNOWN;
    return r;
  endfunction

  // Presents one request and waits for its transfer. A typed reply, where
  // given, replaces the predicted one; the shadow table is updated either way.
  task automatic issue_request(input logic op, input logic [FW-1:0] size,
                               input logic [FW-1:0] off, input bit use_typed,
                               input reply_t typed);
    int unsigned gap;
    reply_t      predicted;
    gap = burst_mode ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    operation_i      <= op;
    request_size_i   <= size;
    payload_offset_i <= off;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = heap_update(op, size, off);
    pending_replies.push_back(use_typed ? typed : predicted);
    requests_sent++;
  endtask

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (in_fire || out_fire) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : reply_checker
    int unsigned stall;
    reply_t      got;
    reply_t      want;
    // Outputs are unknown until the first clock edge under reset.
    wait (rst_ni === 1'b1);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got.offset = result_offset_o;
      got.status = status_o;
      status_seen[got.status]++;
      replies_seen++;
      if (pending_replies.size() == 0) begin
        if (mismatches < 10)
          $display("reply %0d arrived with nothing outstanding: offset %0d status %0d",
                   replies_seen, got.offset, got.status);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (got.offset !== want.offset || got.status !== want.status) begin
          if (mismatches < 10)
            $display("reply %0d: offset exp %0d got %0d, status exp %0d got %0d",
                     replies_seen, want.offset, got.offset, want.status, got.status);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    reply_t        typed;
    logic [FW-1:0] size;
    logic [FW-1:0] off;
    int unsigned   n;
    int unsigned   pick;
    int unsigned   sel;
    bit            want_alloc;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (n = 0; n < N_DIRECTED; n++) begin
      typed.offset = directed_rows[n].exp_off;
      typed.status = directed_rows[n].exp_st;
      issue_request(directed_rows[n].op, directed_rows[n].size, directed_rows[n].off,
                    directed_rows[n].typed, typed);
    end

    // Random mix kept to a modest table so scans stay short.
    for (n = 0; n < N_RANDOM; n++) begin
      if (n % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (shadow_count < 8) want_alloc = (pick < 75);
      else if (shadow_count >= MAX_LIVE) want_alloc = (pick < 25);
      else want_alloc = (pick < 55);
      sel = $urandom_range(0, 99);
      if (want_alloc) begin
        if (sel < 70) size = FW'($urandom_range(0, 255));
        else if (sel < 92) size = FW'($urandom_range(256, 8191));
        else size = FW'($urandom);
        issue_request(ffha_pkg::OP_ALLOC, size, FW'($urandom), 1'b0, '0);
      end else begin
        if (sel < 60 && shadow_count > 0)
          off = shadow_start[$urandom_range(0, shadow_count - 1)] +
                FW'(ffha_pkg::HDR_BYTES);
        else if (sel < 72 && shadow_count > 0)
          off = shadow_start[shadow_count - 1] + FW'(ffha_pkg::HDR_BYTES);
        else if (sel < 82)
          off = '0;
        else if (sel < 90 && shadow_count > 0)
          off = shadow_start[$urandom_range(0, shadow_count - 1)] +
                FW'($urandom_range(1, 31));
        else
          off = FW'($urandom);
        issue_request(ffha_pkg::OP_FREE, FW'($urandom), off, 1'b0, '0);
      end
    end
    burst_mode = 1'b0;

    // Empty the table from the top down so the heap end returns to zero.
    while (shadow_count > 0)
      issue_request(ffha_pkg::OP_FREE, FW'($urandom),
                    shadow_start[shadow_count - 1] + FW'(ffha_pkg::HDR_BYTES), 1'b0, '0);

    // On the empty heap: exhaustion, an unknown offset, one append and its removal.
    issue_request(ffha_pkg::OP_ALLOC, 20'hFFFFF, '0, 1'b0, '0);
    issue_request(ffha_pkg::OP_FREE, '0, 20'd8, 1'b0, '0);
    issue_request(ffha_pkg::OP_ALLOC, 20'd7, '0, 1'b0, '0);
    issue_request(ffha_pkg::OP_FREE, '0,
                  shadow_start[shadow_count - 1] + FW'(ffha_pkg::HDR_BYTES), 1'b0, '0);
    in_valid_i <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (TABLE_DEPTH + 8) @(posedge clk_i);

    $display("%0d requests, %0d replies: %0d ok, %0d heap exhausted, %0d table full,",
             requests_sent, replies_seen, status_seen[ffha_pkg::ST_OK],
             status_seen[ffha_pkg::ST_EXHAUSTED], status_seen[ffha_pkg::ST_FULL]);
    $display("%0d unknown frees; table reached %0d blocks; %0d mismatches.",
             status_seen[ffha_pkg::ST_UNKNOWN], peak_count, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
